[rtl/mvm_pkg.sv]
// Shared types, widths and codes of the matrix-vector multiply block.
`timescale 1ns / 1ps

package mvm_pkg;

   localparam int DATA_W         = 32;
   localparam int ACC_W          = 64;
   localparam int ROW_IDX_W      = 16;
   localparam int NUM_ROWS_W     = 17;
   localparam int NUM_COLS_W     = 13;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 17;
   localparam int RSP_DATA_W     = ACC_W + ROW_IDX_W;

   localparam int MAX_COLS_DEFAULT = 4096;
   localparam int MAX_ROWS_DEFAULT = 65536;

   localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RESET = 17'd4096;
   localparam logic [NUM_COLS_W-1:0] NUM_COLS_RESET = 13'd4096;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_ROWS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_COLS = 1'b1;

   localparam logic KIND_VECTOR = 1'b0;
   localparam logic KIND_MATRIX = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC
   } ctrl_state_type;

   typedef struct packed {
      logic accept_vec;
      logic accept_mat;
      logic mul_en;
      logic acc_en;
   } ctrl_cmd_type;

   typedef struct packed {
      logic row_end;
   } dp_status_type;

endpackage

[rtl/matrix_vector_multiply_top.sv]
// Top level of the fixed-point matrix-vector multiply block.
// A vector word is stored while the input stays ready; a matrix word holds the
// input off through store read, multiply register and saturating accumulate,
// set by the controller's sequence. The accumulate step that ends a row waits while
// the previous row result is unread; the row result is registered as it finishes.
// Reset clears counters, accumulator and result valid and sets both sizes to 4096.
`timescale 1ns / 1ps

module matrix_vector_multiply_top #(
   parameter int MAX_COLS = mvm_pkg::MAX_COLS_DEFAULT,
   parameter int MAX_ROWS = mvm_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [mvm_pkg::DATA_W-1:0]           req_tdata,   // [31:0] element_value
   input  logic [0:0]                           req_tuser,   // [0] kind
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mvm_pkg::RSP_DATA_W-1:0]       rsp_tdata,   // [63:0] row_result, [79:64] row_index
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [mvm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mvm_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   mvm_pkg::ctrl_cmd_type  cmd;
   mvm_pkg::dp_status_type status;

   mvm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mvm_datapath #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .element_value (req_tdata),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast)
   );

endmodule

[rtl/mvm_ctrl.sv]
// Controller state machine that sequences each word and owns the result valid flag.
`timescale 1ns / 1ps

module mvm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_kind,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  mvm_pkg::dp_status_type status,
   output mvm_pkg::ctrl_cmd_type  cmd
);

   mvm_pkg::ctrl_state_type state_ff, state_in;
   logic out_valid_ff, out_valid_in;
   logic acc_go;

   // The accumulate step may finish unless it must load a result that cannot be held.
   assign acc_go = !status.row_end || !out_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mvm_pkg::ST_IDLE: begin
            if (req_tvalid && (req_kind == mvm_pkg::KIND_MATRIX)) begin
               state_in = mvm_pkg::ST_MUL;
            end
         end
         mvm_pkg::ST_MUL: begin
            state_in = mvm_pkg::ST_ACC;
         end
         mvm_pkg::ST_ACC: begin
            if (acc_go) begin
               state_in = mvm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mvm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready     = (state_ff == mvm_pkg::ST_IDLE) && !reset;
      cmd.accept_vec = req_tready && req_tvalid && (req_kind == mvm_pkg::KIND_VECTOR);
      cmd.accept_mat = req_tready && req_tvalid && (req_kind == mvm_pkg::KIND_MATRIX);
      cmd.mul_en     = (state_ff == mvm_pkg::ST_MUL);
      cmd.acc_en     = (state_ff == mvm_pkg::ST_ACC) && acc_go;
   end

   always_comb begin
      priority if (cmd.acc_en && status.row_end) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mvm_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

[rtl/mvm_datapath.sv]
// Datapath with the vector store, counters, multiplier, saturating accumulator and result register.
`timescale 1ns / 1ps

module mvm_datapath #(
   parameter int MAX_COLS = mvm_pkg::MAX_COLS_DEFAULT,
   parameter int MAX_ROWS = mvm_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mvm_pkg::ctrl_cmd_type                  cmd,
   output mvm_pkg::dp_status_type                 status,
   input  logic signed [mvm_pkg::DATA_W-1:0]      element_value,
   input  logic                                   csr_we,
   input  logic [mvm_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [mvm_pkg::CSR_DATA_W-1:0]         csr_wdata,
   output logic [mvm_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                   rsp_tlast
);

   localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   logic [mvm_pkg::NUM_ROWS_W-1:0] num_rows_ff;
   logic [mvm_pkg::NUM_COLS_W-1:0] num_cols_ff;
   logic [mvm_pkg::NUM_ROWS_W-1:0] eff_rows;
   logic [mvm_pkg::NUM_COLS_W-1:0] eff_cols;

   logic [mvm_pkg::DATA_W-1:0] vec_mem [MAX_COLS];

   logic [AW-1:0] load_pos_ff, load_pos_in;
   logic [AW-1:0] col_pos_ff, col_pos_in;
   logic [mvm_pkg::ROW_IDX_W-1:0] row_pos_ff, row_pos_in;
   logic row_end_now, last_now;

   logic signed [mvm_pkg::DATA_W-1:0] elem_ff;
   logic signed [mvm_pkg::DATA_W-1:0] x_ff;
   logic signed [mvm_pkg::ACC_W-1:0]  prod_ff;
   logic signed [mvm_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic                              row_end_ff;
   logic                              last_ff;
   logic [mvm_pkg::ROW_IDX_W-1:0]     row_idx_ff;

   logic [mvm_pkg::ACC_W:0]           sum_wide;
   logic [mvm_pkg::ACC_W-1:0]         sum_sat;

   logic [mvm_pkg::ACC_W-1:0]         out_result_ff;
   logic [mvm_pkg::ROW_IDX_W-1:0]     out_index_ff;
   logic                              out_last_ff;

   // A zero count acts as one; a count beyond the storage limit saturates to it.
   always_comb begin
      priority if (num_cols_ff == '0) begin
         eff_cols = mvm_pkg::NUM_COLS_W'(1);
      end else if (32'(num_cols_ff) > 32'(MAX_COLS)) begin
         eff_cols = mvm_pkg::NUM_COLS_W'(MAX_COLS);
      end else begin
         eff_cols = num_cols_ff;
      end
      priority if (num_rows_ff == '0) begin
         eff_rows = mvm_pkg::NUM_ROWS_W'(1);
      end else if (32'(num_rows_ff) > 32'(MAX_ROWS)) begin
         eff_rows = mvm_pkg::NUM_ROWS_W'(MAX_ROWS);
      end else begin
         eff_rows = num_rows_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= mvm_pkg::NUM_ROWS_RESET;
         num_cols_ff <= mvm_pkg::NUM_COLS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            mvm_pkg::CSR_NUM_ROWS: num_rows_ff <= csr_wdata[mvm_pkg::NUM_ROWS_W-1:0];
            mvm_pkg::CSR_NUM_COLS: num_cols_ff <= csr_wdata[mvm_pkg::NUM_COLS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      row_end_now = (32'(col_pos_ff) + 32'd1) >= 32'(eff_cols);
      last_now    = (32'(row_pos_ff) + 32'd1) >= 32'(eff_rows);

      load_pos_in = load_pos_ff;
      if (cmd.accept_vec) begin
         if ((32'(load_pos_ff) + 32'd1) >= 32'(eff_cols)) begin
            load_pos_in = '0;
         end else begin
            load_pos_in = load_pos_ff + AW'(1);
         end
      end

      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (cmd.accept_mat) begin
         if (row_end_now) begin
            col_pos_in = '0;
            row_pos_in = last_now ? '0 : row_pos_ff + mvm_pkg::ROW_IDX_W'(1);
         end else begin
            col_pos_in = col_pos_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff <= '0;
         col_pos_ff  <= '0;
         row_pos_ff  <= '0;
      end else begin
         load_pos_ff <= load_pos_in;
         col_pos_ff  <= col_pos_in;
         row_pos_ff  <= row_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_vec) begin
         vec_mem[load_pos_ff] <= element_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_mat) begin
         x_ff       <= vec_mem[col_pos_ff];
         elem_ff    <= element_value;
         row_end_ff <= row_end_now;
         last_ff    <= last_now;
         row_idx_ff <= row_pos_ff;
      end
      if (cmd.mul_en) begin
         prod_ff <= elem_ff * x_ff;
      end
   end

   always_comb begin
      sum_wide = {acc_ff[mvm_pkg::ACC_W-1], acc_ff} + {prod_ff[mvm_pkg::ACC_W-1], prod_ff};
      if (sum_wide[mvm_pkg::ACC_W] != sum_wide[mvm_pkg::ACC_W-1]) begin
         sum_sat = sum_wide[mvm_pkg::ACC_W] ? {1'b1, {(mvm_pkg::ACC_W-1){1'b0}}}
                                            : {1'b0, {(mvm_pkg::ACC_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[mvm_pkg::ACC_W-1:0];
      end
      acc_in = acc_ff;
      if (cmd.acc_en) begin
         acc_in = row_end_ff ? '0 : sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_en && row_end_ff) begin
         out_result_ff <= sum_sat;
         out_index_ff  <= row_idx_ff;
         out_last_ff   <= last_ff;
      end
   end

   assign status.row_end = row_end_ff;
   assign rsp_tdata      = {out_index_ff, out_result_ff};
   assign rsp_tlast      = out_last_ff;

endmodule

[rtl/mvm_checker.sv]
// Port-level checker for the matrix-vector multiply block and its bind.
`timescale 1ns / 1ps

module mvm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [0:0]                     req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mvm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);

   // No result is shown in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result word holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // A matrix word occupies the block for the following cycles.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == mvm_pkg::KIND_MATRIX) |=> !req_tready)
      else $error("input taken while a matrix word is in progress");

   // A new result follows a matrix word that was taken and then passed the multiply and accumulate states.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |->
         $past(req_tvalid && req_tready && (req_tuser[0] == mvm_pkg::KIND_MATRIX), 3))
      else $error("result without a matching matrix word");

endmodule

bind matrix_vector_multiply_top mvm_checker u_mvm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

[tb/sv/tb_matrix_vector_multiply_top.sv]
// Self-checking testbench for the fixed-point matrix-vector multiply block.
`timescale 1ns / 1ps

module tb_matrix_vector_multiply_top;

   localparam int unsigned COLS_LIMIT       = mvm_pkg::MAX_COLS_DEFAULT;
   localparam int unsigned ROWS_LIMIT       = mvm_pkg::MAX_ROWS_DEFAULT;
   localparam int unsigned CYCLE_LIMIT      = 1000000;
   localparam int unsigned RANDOM_WORDS     = 520;
   localparam int unsigned SETTLE_CYCLES    = 8;
   localparam int unsigned LONG_HOLD_CYCLES = 400;
   localparam int unsigned WIDE_COLS        = 160;

   localparam logic [mvm_pkg::DATA_W-1:0] Q_MOST_NEG = 32'h8000_0000;
   localparam logic [mvm_pkg::DATA_W-1:0] Q_MOST_POS = 32'h7FFF_FFFF;
   localparam logic [mvm_pkg::DATA_W-1:0] Q_ONE      = 32'h0001_0000;
   localparam logic [mvm_pkg::DATA_W-1:0] Q_MINUS_1  = 32'hFFFF_0000;

   typedef struct packed {
      logic                       kind;
      logic [mvm_pkg::DATA_W-1:0] value;
   } element_word_type;

   typedef struct packed {
      logic [mvm_pkg::ACC_W-1:0]     row_sum;
      logic [mvm_pkg::ROW_IDX_W-1:0] row_index;
      logic                          last_row;
   } row_sum_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [mvm_pkg::DATA_W-1:0]      req_tdata = '0;
   logic [0:0]                      req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [mvm_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_we = 1'b0;
   logic [mvm_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [mvm_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // Expected behavior of the block.
   logic [mvm_pkg::DATA_W-1:0]       x_store [COLS_LIMIT];
   int unsigned                      x_load_pos = 0;
   logic signed [mvm_pkg::ACC_W-1:0] dot_acc = '0;
   int unsigned                      dot_col = 0;
   int unsigned                      dot_row = 0;
   logic [mvm_pkg::NUM_ROWS_W-1:0]   rows_reg = mvm_pkg::NUM_ROWS_RESET;
   logic [mvm_pkg::NUM_COLS_W-1:0]   cols_reg = mvm_pkg::NUM_COLS_RESET;
   row_sum_type                      row_sums [$];

   // Stimulus-side positions, kept so that no matrix word reads an entry of x
   // that was never loaded.
   bit                      x_loaded [COLS_LIMIT];
   int unsigned             plan_load_pos = 0;
   int unsigned             plan_col = 0;
   element_word_type        pending_words [$];
   int unsigned             words_in_flight = 0;
   int unsigned             random_words = 0;

   int unsigned             send_gap = 0;
   int unsigned             stall_left = 0;
   int unsigned             hold_left = 0;
   bit                      long_hold_req = 1'b0;
   bit                      steady_flow = 1'b0;
   int unsigned             cycle_count = 0;
   int unsigned             mismatches = 0;

   matrix_vector_multiply_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned clamp_size(int unsigned value, int unsigned limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   function automatic void predict_word(element_word_type w);
      int unsigned                      cols;
      logic signed [mvm_pkg::ACC_W-1:0] prod;
      logic signed [mvm_pkg::ACC_W:0]   sum;
      row_sum_type                      r;
      cols = clamp_size(cols_reg, COLS_LIMIT);
      if (w.kind == mvm_pkg::KIND_VECTOR) begin
         x_store[x_load_pos] = w.value;
         x_load_pos = (x_load_pos + 1 >= cols) ? 0 : x_load_pos + 1;
      end else begin
         prod = $signed(w.value) * $signed(x_store[dot_col]);
         sum = dot_acc + prod;
         if (sum[mvm_pkg::ACC_W] != sum[mvm_pkg::ACC_W-1]) begin
            dot_acc = sum[mvm_pkg::ACC_W] ? {1'b1, {(mvm_pkg::ACC_W-1){1'b0}}}
                                          : {1'b0, {(mvm_pkg::ACC_W-1){1'b1}}};
         end else begin
            dot_acc = sum[mvm_pkg::ACC_W-1:0];
         end
         if (dot_col + 1 < cols) begin
            dot_col++;
         end else begin
            r.row_sum = dot_acc;
            r.row_index = dot_row[mvm_pkg::ROW_IDX_W-1:0];
            r.last_row = (dot_row + 1 >= clamp_size(rows_reg, ROWS_LIMIT));
            dot_row = r.last_row ? 0 : (dot_row + 1) % (1 << mvm_pkg::ROW_IDX_W);
            row_sums.push_back(r);
            dot_acc = '0;
            dot_col = 0;
         end
      end
   endfunction

   function automatic void queue_word(logic kind, logic [mvm_pkg::DATA_W-1:0] value);
      element_word_type w;
      int unsigned      cols;
      cols = clamp_size(cols_reg, COLS_LIMIT);
      w.kind = kind;
      w.value = value;
      if (kind == mvm_pkg::KIND_MATRIX && !x_loaded[plan_col]) w.kind = mvm_pkg::KIND_VECTOR;
      if (w.kind == mvm_pkg::KIND_VECTOR) begin
         x_loaded[plan_load_pos] = 1'b1;
         plan_load_pos = (plan_load_pos + 1 >= cols) ? 0 : plan_load_pos + 1;
      end else begin
         plan_col = (plan_col + 1 >= cols) ? 0 : plan_col + 1;
      end
      pending_words.push_back(w);
      words_in_flight++;
   endfunction

   function automatic logic [mvm_pkg::DATA_W-1:0] rand_element();
      case ($urandom_range(0, 7))
         0: return Q_MOST_NEG;
         1: return Q_MOST_POS;
         2: return $urandom_range(0, 32'h0002_0000);
         3: return ~$urandom_range(0, 32'h0002_0000);
         default: return $urandom;
      endcase
   endfunction

   task automatic wait_idle();
      do @(negedge clock); while (words_in_flight != 0 || row_sums.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [mvm_pkg::CSR_INDEX_W-1:0] index, int unsigned value);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[mvm_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == mvm_pkg::CSR_NUM_ROWS) rows_reg = value[mvm_pkg::NUM_ROWS_W-1:0];
      else cols_reg = value[mvm_pkg::NUM_COLS_W-1:0];
   endtask

   task automatic run_random_phase();
      int unsigned budget;
      int unsigned count;
      int unsigned cols;
      int unsigned rows;
      case ($urandom_range(0, 9))
         0: write_reg(mvm_pkg::CSR_NUM_COLS, 0);
         1: write_reg(mvm_pkg::CSR_NUM_COLS, $urandom_range(9, 40));
         2: ;
         default: write_reg(mvm_pkg::CSR_NUM_COLS, $urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 9))
         0: write_reg(mvm_pkg::CSR_NUM_ROWS, 0);
         1: write_reg(mvm_pkg::CSR_NUM_ROWS, $urandom_range(65535, 131071));
         2: ;
         default: write_reg(mvm_pkg::CSR_NUM_ROWS, $urandom_range(1, 6));
      endcase
      budget = $urandom_range(60, 140);
      count = 0;
      while (count < budget) begin
         cols = clamp_size(cols_reg, COLS_LIMIT);
         if ($urandom_range(0, 3) != 0) begin
            rows = $urandom_range(1, 4);
            repeat (cols) queue_word(mvm_pkg::KIND_VECTOR, rand_element());
            repeat (rows * cols) queue_word(mvm_pkg::KIND_MATRIX, rand_element());
            count += cols * (rows + 1);
         end else begin
            rows = $urandom_range(1, 8);
            repeat (rows) queue_word(1'($urandom_range(0, 1)), rand_element());
            count += rows;
         end
      end
      random_words += count;
   endtask

   always @(posedge clock) begin
      element_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            w.kind = req_tuser[0];
            w.value = req_tdata;
            predict_word(w);
            words_in_flight--;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() != 0 && !steady_flow &&
                         $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 10);
               req_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               w = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= w.kind;
               req_tdata <= w.value;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (steady_flow) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      row_sum_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (row_sums.size() == 0) begin
            $display("%0t: row word with none expected: sum %h row %0d last %b",
                     $time, rsp_tdata[mvm_pkg::ACC_W-1:0],
                     rsp_tdata[mvm_pkg::ACC_W +: mvm_pkg::ROW_IDX_W], rsp_tlast);
            mismatches++;
         end else begin
            want = row_sums.pop_front();
            if (rsp_tdata[mvm_pkg::ACC_W-1:0] !== want.row_sum) begin
               $display("%0t: row_result expected %h actual %h",
                        $time, want.row_sum, rsp_tdata[mvm_pkg::ACC_W-1:0]);
               mismatches++;
            end
            if (rsp_tdata[mvm_pkg::ACC_W +: mvm_pkg::ROW_IDX_W] !== want.row_index) begin
               $display("%0t: row_index expected %0d actual %0d",
                        $time, want.row_index, rsp_tdata[mvm_pkg::ACC_W +: mvm_pkg::ROW_IDX_W]);
               mismatches++;
            end
            if (rsp_tlast !== want.last_row) begin
               $display("%0t: last_row expected %b actual %b", $time, want.last_row, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_matrix_vector_multiply_top: errors");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_reg(mvm_pkg::CSR_NUM_COLS, 4);
      write_reg(mvm_pkg::CSR_NUM_ROWS, 2);
      queue_word(mvm_pkg::KIND_VECTOR, Q_MOST_NEG);
      queue_word(mvm_pkg::KIND_VECTOR, Q_MOST_POS);
      queue_word(mvm_pkg::KIND_VECTOR, Q_MOST_NEG);
      queue_word(mvm_pkg::KIND_VECTOR, Q_ONE);
      // The first row saturates high, the second one low and ends the matrix.
      queue_word(mvm_pkg::KIND_MATRIX, Q_MOST_NEG);
      queue_word(mvm_pkg::KIND_MATRIX, '0);
      queue_word(mvm_pkg::KIND_MATRIX, Q_MOST_NEG);
      queue_word(mvm_pkg::KIND_MATRIX, '0);
      queue_word(mvm_pkg::KIND_MATRIX, Q_MOST_POS);
      queue_word(mvm_pkg::KIND_MATRIX, Q_MOST_NEG);
      queue_word(mvm_pkg::KIND_MATRIX, Q_MOST_POS);
      queue_word(mvm_pkg::KIND_MATRIX, Q_MINUS_1);
      // Entries of x are rewritten while a row is halfway through.
      queue_word(mvm_pkg::KIND_MATRIX, Q_ONE);
      queue_word(mvm_pkg::KIND_MATRIX, Q_ONE);
      queue_word(mvm_pkg::KIND_VECTOR, Q_MOST_POS);
      queue_word(mvm_pkg::KIND_VECTOR, '0);
      queue_word(mvm_pkg::KIND_VECTOR, 32'h0003_0000);
      queue_word(mvm_pkg::KIND_MATRIX, Q_ONE);
      queue_word(mvm_pkg::KIND_MATRIX, Q_MINUS_1);

      write_reg(mvm_pkg::CSR_NUM_COLS, 0);
      write_reg(mvm_pkg::CSR_NUM_ROWS, 0);
      queue_word(mvm_pkg::KIND_VECTOR, Q_MOST_POS);
      queue_word(mvm_pkg::KIND_MATRIX, Q_MOST_POS);
      queue_word(mvm_pkg::KIND_MATRIX, Q_MOST_NEG);

      write_reg(mvm_pkg::CSR_NUM_COLS, 8191);
      write_reg(mvm_pkg::CSR_NUM_ROWS, 131071);
      repeat (3) queue_word(mvm_pkg::KIND_VECTOR, rand_element());
      repeat (2) queue_word(mvm_pkg::KIND_MATRIX, rand_element());
      write_reg(mvm_pkg::CSR_NUM_COLS, 2);
      queue_word(mvm_pkg::KIND_MATRIX, rand_element());
      queue_word(mvm_pkg::KIND_VECTOR, rand_element());

      // The receiver holds off long enough for the block to stall its input.
      write_reg(mvm_pkg::CSR_NUM_COLS, 1);
      write_reg(mvm_pkg::CSR_NUM_ROWS, 5);
      long_hold_req = 1'b1;
      repeat (48) queue_word(mvm_pkg::KIND_MATRIX, rand_element());
      wait_idle();

      while (random_words < RANDOM_WORDS) run_random_phase();

      write_reg(mvm_pkg::CSR_NUM_COLS, WIDE_COLS);
      write_reg(mvm_pkg::CSR_NUM_ROWS, 2);
      repeat (WIDE_COLS) queue_word(mvm_pkg::KIND_VECTOR, rand_element());
      repeat (2 * WIDE_COLS) queue_word(mvm_pkg::KIND_MATRIX, rand_element());
      repeat (3) queue_word(mvm_pkg::KIND_VECTOR, rand_element());

      wait_idle();
      steady_flow = 1'b1;
      write_reg(mvm_pkg::CSR_NUM_COLS, 3);
      write_reg(mvm_pkg::CSR_NUM_ROWS, 65536);
      repeat (10) begin
         repeat (3) queue_word(mvm_pkg::KIND_VECTOR, rand_element());
         repeat (9) queue_word(mvm_pkg::KIND_MATRIX, rand_element());
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("tb_matrix_vector_multiply_top: clean");
      end else begin
         $display("tb_matrix_vector_multiply_top: errors");
      end
      $finish;
   end

endmodule
